@@ hw/rtl/mpfb_pkg.sv @@
package mpfb_pkg;

  // Geometry of the page-organised store
  localparam int unsigned Width      = 128;
  localparam int unsigned MaxRows    = 64;
  localparam int unsigned PageRows   = 8;
  localparam int unsigned Pages      = (MaxRows + PageRows - 1) / PageRows;
  localparam int unsigned StoreBytes = Width * Pages;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned ColW       = $clog2(Width);
  localparam int unsigned PageW      = $clog2(Pages);

  // Operation codes
  localparam logic [1:0] OpPixel = 2'd0;
  localparam logic [1:0] OpRect  = 2'd1;
  localparam logic [1:0] OpBlit  = 2'd2;
  localparam logic [1:0] OpRead  = 2'd3;

  // Pixel mode codes (anything above set toggles)
  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeSet   = 2'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;   // clearing pass: write zero at the sweep address
    logic capture;  // input beat taken: latch fields, restart walks
    logic rd;       // read the byte of the current job
    logic wr;       // write back the modified byte
    logic step;     // move to the next job of a multi-byte item
    logic finish;   // load the result register, advance the blit cursor
  } mpfb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done; // last byte of the clearing pass is being written
    logic last;     // current job is the last one of the item
  } mpfb_status_t;

endpackage

@@ hw/rtl/mpfb_ctrl.sv @@
module mpfb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  mpfb_pkg::mpfb_status_t status_i,
  output mpfb_pkg::mpfb_cmd_t    cmd_o
);
  import mpfb_pkg::*;

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StWr   = 3'd3;
  localparam logic [2:0] StHold = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       finish;
  logic       accept;

  // Result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = ((state_q == StWr && status_i.last) || state_q == StHold) && out_free;

  assign in_stall_o = !(state_q == StIdle || finish);
  assign accept     = in_valid_i && !in_stall_o;

  // Commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.clr_wr  = (state_q == StClr);
    cmd_o.capture = accept;
    cmd_o.rd      = (state_q == StRd);
    cmd_o.wr      = (state_q == StWr);
    cmd_o.step    = (state_q == StWr) && !status_i.last;
    cmd_o.finish  = finish;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClr: begin
        if (status_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (accept) state_d = StRd;
      end
      StRd: begin
        state_d = StWr;
      end
      StWr: begin
        if (!status_i.last) state_d = StRd;
        else if (finish)    state_d = accept ? StRd : StIdle;
        else                state_d = StHold;
      end
      StHold: begin
        if (finish) state_d = accept ? StRd : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Output beat valid
  assign out_valid_d = finish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StRd)
    else $error("accepted beat did not start a read");

  a_rd_then_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRd |=> state_q == StWr)
    else $error("read not followed by write-back");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("finished item produced no result");

  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClr |-> (in_stall_o && !out_valid_q))
    else $error("activity during clearing pass");
`endif

endmodule

@@ hw/rtl/mpfb_datapath.sv @@
module mpfb_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mpfb_pkg::mpfb_cmd_t    cmd_i,
  output mpfb_pkg::mpfb_status_t status_o,
  input  logic                   cfg_we_i,
  input  logic [6:0]             cfg_data_i,
  input  logic [1:0]             op_i,
  input  logic [7:0]             x_start_i,
  input  logic [7:0]             y_start_i,
  input  logic [7:0]             x_end_i,
  input  logic [7:0]             y_end_i,
  input  logic [1:0]             pixel_mode_i,
  input  logic [7:0]             bitmap_byte_i,
  input  logic                   first_byte_i,
  output logic [7:0]             read_data_o
);
  import mpfb_pkg::*;

  // Mask of the rows of page pg that lie below the row limit
  function automatic logic [7:0] page_clip(input logic [6:0] pg, input logic [6:0] lim);
    logic [9:0] base;
    logic [9:0] rem;
    logic [7:0] m;
    base = {pg, 3'b000};
    rem  = {3'b000, lim} - base;
    if (base >= {3'b000, lim}) m = 8'h00;
    else if (rem >= 10'd8)     m = 8'hFF;
    else                       m = 8'((9'd1 << rem[2:0]) - 9'd1);
    return m;
  endfunction

  logic [7:0] mem [StoreBytes];

  logic [6:0]       panel_rows_q;
  logic [1:0]       op_q;
  logic [7:0]       xs_q, ys_q, xe_q, ye_q;
  logic [1:0]       mode_q;
  logic [7:0]       data_q;
  logic [7:0]       bcol_q, bcol_d;
  logic [5:0]       bpage_q, bpage_d;
  logic [7:0]       wx_q;
  logic [2:0]       wpg_q;
  logic             phase_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic [7:0]       rdata_q;
  logic [7:0]       read_data_q;

  logic [6:0]       lim;

  // Blit signals
  logic             win_empty;
  logic [8:0]       sizex, sizey;
  logic [5:0]       bpages;
  logic [3:0]       last_rows, rows;
  logic             b_live;
  logic [7:0]       rmask;
  logic [9:0]       y0;
  logic [15:0]      bw_mask, bw_val;
  logic [8:0]       bx;
  logic [8:0]       col_nx;

  // Rectangle signals
  logic [7:0]       xhi, yhi;
  logic             r_empty;
  logic [7:0]       r_lo, r_hi;

  // Current job
  logic [8:0]       job_x;
  logic [6:0]       job_pg;
  logic [7:0]       job_mask, job_val;
  logic             job_tog, job_last;
  logic [7:0]       eff_mask;
  logic [AddrW-1:0] addr;
  logic [7:0]       new_byte;
  logic             wr_en;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  // Row limit: panel rows capped at the store height
  assign lim = (panel_rows_q > 7'(MaxRows)) ? 7'(MaxRows) : panel_rows_q;

  // Blit window and cursor geometry
  assign win_empty = (xe_q < xs_q) || (ye_q < ys_q);
  assign sizex     = {1'b0, xe_q} - {1'b0, xs_q} + 9'd1;
  assign sizey     = {1'b0, ye_q} - {1'b0, ys_q} + 9'd1;
  assign bpages    = 6'(({1'b0, sizey} + 10'd7) >> 3);
  assign last_rows = (sizey[2:0] == 3'd0) ? 4'd8 : {1'b0, sizey[2:0]};
  assign b_live    = !win_empty && (bpage_q < bpages);
  assign rows      = (bpage_q == bpages - 6'd1) ? last_rows : 4'd8;
  assign rmask     = 8'((9'd1 << rows) - 9'd1);
  assign y0        = {2'b00, ys_q} + {1'b0, bpage_q, 3'b000};
  assign bw_mask   = {8'h00, rmask} << y0[2:0];
  assign bw_val    = {8'h00, data_q} << y0[2:0];
  assign bx        = {1'b0, xs_q} + {1'b0, bcol_q};
  assign col_nx    = {1'b0, bcol_q} + 9'd1;

  // Rectangle clipped bounds and page masks
  assign xhi     = (xe_q > 8'(Width - 1)) ? 8'(Width - 1) : xe_q;
  assign r_empty = win_empty || ({1'b0, xs_q} >= 9'(Width)) || (ys_q >= {1'b0, lim});
  assign yhi     = (ye_q < {1'b0, lim}) ? ye_q : ({1'b0, lim} - 8'd1);
  assign r_lo    = (wpg_q == ys_q[5:3]) ? (8'hFF << ys_q[2:0]) : 8'hFF;
  assign r_hi    = (wpg_q == yhi[5:3]) ? (8'hFF >> (3'd7 - yhi[2:0])) : 8'hFF;

  // Job select
  always_comb begin
    job_x    = {1'b0, xs_q};
    job_pg   = {2'b00, ys_q[7:3]};
    job_mask = 8'h01 << ys_q[2:0];
    job_val  = 8'h00;
    job_tog  = 1'b0;
    job_last = 1'b1;
    unique case (op_q)
      OpPixel: begin
        job_tog = mode_q[1];
        job_val = {8{mode_q[0]}};
      end
      OpRect: begin
        job_x    = {1'b0, wx_q};
        job_pg   = {4'b0000, wpg_q};
        job_mask = r_empty ? 8'h00 : (r_lo & r_hi);
        job_val  = {8{mode_q != ModeClear}};
        job_last = r_empty || (wx_q == xhi && wpg_q == yhi[5:3]);
      end
      OpBlit: begin
        job_x    = bx;
        job_pg   = y0[9:3] + {6'b000000, phase_q};
        job_mask = !b_live ? 8'h00 : (phase_q ? bw_mask[15:8] : bw_mask[7:0]);
        job_val  = phase_q ? bw_val[15:8] : bw_val[7:0];
        job_last = !b_live || phase_q || (y0[2:0] == 3'd0);
      end
      OpRead: begin
        job_last = 1'b1;
      end
      default: job_last = 1'b1;
    endcase
  end

  // Clip to the panel and build the write-back byte
  assign eff_mask = job_mask & page_clip(job_pg, lim) & {8{job_x < 9'(Width)}};
  assign addr     = {job_pg[PageW-1:0], job_x[ColW-1:0]};
  assign new_byte = job_tog ? (rdata_q ^ eff_mask)
                            : ((rdata_q & ~eff_mask) | (job_val & eff_mask));
  assign wr_en    = cmd_i.wr && (op_q != OpRead) && (eff_mask != 8'h00);

  assign mem_we    = cmd_i.clr_wr || wr_en;
  assign mem_waddr = cmd_i.clr_wr ? clr_cnt_q : addr;
  assign mem_wdata = cmd_i.clr_wr ? 8'h00 : new_byte;

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.rd) rdata_q <= mem[addr];
  end

  // Blit cursor: advance after a used byte, restart on first byte
  always_comb begin
    bcol_d  = bcol_q;
    bpage_d = bpage_q;
    if (cmd_i.finish && op_q == OpBlit && b_live) begin
      if (col_nx >= sizex) begin
        bcol_d  = 8'h00;
        bpage_d = bpage_q + 6'd1;
      end else begin
        bcol_d = col_nx[7:0];
      end
    end
    if (cmd_i.capture && op_i == OpBlit && first_byte_i) begin
      bcol_d  = 8'h00;
      bpage_d = 6'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_rows_q <= 7'(MaxRows);
      bcol_q       <= 8'h00;
      bpage_q      <= 6'd0;
      clr_cnt_q    <= '0;
      phase_q      <= 1'b0;
      wx_q         <= 8'h00;
      wpg_q        <= 3'd0;
    end else begin
      if (cfg_we_i) panel_rows_q <= cfg_data_i;
      bcol_q  <= bcol_d;
      bpage_q <= bpage_d;
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + AddrW'(1);
      if (cmd_i.capture) begin
        phase_q <= 1'b0;
        wx_q    <= x_start_i;
        wpg_q   <= y_start_i[5:3];
      end else if (cmd_i.step) begin
        if (op_q == OpBlit) begin
          phase_q <= 1'b1;
        end else if (wx_q == xhi) begin
          wx_q  <= xs_q;
          wpg_q <= wpg_q + 3'd1;
        end else begin
          wx_q <= wx_q + 8'd1;
        end
      end
    end
  end

  // Input beat and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      xs_q   <= x_start_i;
      ys_q   <= y_start_i;
      xe_q   <= x_end_i;
      ye_q   <= y_end_i;
      mode_q <= pixel_mode_i;
      data_q <= bitmap_byte_i;
    end
    if (cmd_i.finish) begin
      read_data_q <= (op_q == OpRead && eff_mask != 8'h00) ? rdata_q : 8'h00;
    end
  end

  assign read_data_o       = read_data_q;
  assign status_o.clr_done = (clr_cnt_q == AddrW'(StoreBytes - 1));
  assign status_o.last     = job_last;

endmodule

@@ hw/rtl/mono_page_framebuffer_draw_top.sv @@
// Page-organised monochrome frame store with pixel, rectangle, blit and read
// operations.
//
// Input: one beat per item (op, window, mode, bitmap byte, first flag), taken
// when in_valid_i is high and in_stall_o is low. Output: exactly one
// read_data_o beat per item, taken when out_valid_o is high and out_stall_i
// is low. Config: panel row count, written when cfg_valid_i and cfg_ready_o
// are high (always ready); the user must write only while idle (unenforced).
//
// Each byte touched costs a read and a write-back of the store: pixel, read,
// ignored blit and page-aligned blit items touch one byte, a used blit byte
// starting mid-page touches two, a rectangle one per store byte of its
// clipped window (one if none). The result register is loaded at the last
// byte's write-back, or later if it still holds an unaccepted result; a new
// item is taken in the cycle the previous result is loaded.
//
// After reset the store is swept to zero, one byte a cycle, with the input
// stalled. A stalled result holds in the output register; the next item is
// still processed, and stalls only when its own result is ready while the
// register is still full.
module mono_page_framebuffer_draw_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic [1:0] pixel_mode_i,
  input  logic [7:0] bitmap_byte_i,
  input  logic       first_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);
  import mpfb_pkg::*;

  mpfb_cmd_t    cmd;
  mpfb_status_t status;
  logic         cfg_we;

  // Config register is always writable
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  mpfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mpfb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .pixel_mode_i  (pixel_mode_i),
    .bitmap_byte_i (bitmap_byte_i),
    .first_byte_i  (first_byte_i),
    .read_data_o   (read_data_o)
  );

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpfb_pkg::*;

  // Pixel modes above set: both toggle for pixels, both set for rectangles
  localparam logic [1:0] ModeToggle    = 2'd2;
  localparam logic [1:0] ModeToggleAlt = 2'd3;
  localparam logic [6:0] RowsAtReset   = 7'd64;
  localparam int unsigned IdlePct      = 34;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] xs;
    logic [7:0] ys;
    logic [7:0] xe;
    logic [7:0] ye;
    logic [1:0] mode;
    logic [7:0] bits;
    logic       first;
  } draw_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] op_i = '0;
  logic [7:0] x_start_i = '0;
  logic [7:0] y_start_i = '0;
  logic [7:0] x_end_i = '0;
  logic [7:0] y_end_i = '0;
  logic [1:0] pixel_mode_i = '0;
  logic [7:0] bitmap_byte_i = '0;
  logic       first_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_data_o;

  mono_page_framebuffer_draw_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .pixel_mode_i  (pixel_mode_i),
    .bitmap_byte_i (bitmap_byte_i),
    .first_byte_i  (first_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow frame store, blit cursor and row register
  logic [7:0]  shadow_store [StoreBytes];
  logic [6:0]  rows_cfg = RowsAtReset;
  int          blit_col = 0;
  int          blit_pg = 0;

  draw_item_t  draw_q [$];
  logic [7:0]  read_data_want_q [$];
  int unsigned beats_sent = 0;
  int unsigned beats_taken = 0;
  bit          steady = 1'b0;
  bit          failed = 1'b0;

  function automatic int rows_visible();
    return (rows_cfg > MaxRows) ? MaxRows : rows_cfg;
  endfunction

  function automatic void plot(int x, int y, logic [1:0] mode);
    int         addr;
    logic [7:0] mask;
    if (x >= Width || y >= rows_visible()) return;
    addr = (y / PageRows) * Width + x;
    mask = 8'h01 << (y % PageRows);
    case (mode)
      ModeClear: shadow_store[addr] = shadow_store[addr] & ~mask;
      ModeSet:   shadow_store[addr] = shadow_store[addr] | mask;
      default:   shadow_store[addr] = shadow_store[addr] ^ mask;
    endcase
  endfunction

  // Rectangle: any non-clear mode sets; loops clipped up front
  function automatic void fill_window(draw_item_t it);
    int         x_hi;
    int         y_hi;
    logic [1:0] m;
    m = (it.mode == ModeClear) ? ModeClear : ModeSet;
    x_hi = (int'(it.xe) < Width) ? int'(it.xe) : Width - 1;
    y_hi = (int'(it.ye) < rows_visible()) ? int'(it.ye) : rows_visible() - 1;
    for (int x = it.xs; x <= x_hi; x++)
      for (int y = it.ys; y <= y_hi; y++)
        plot(x, y, m);
  endfunction

  // One bitmap byte into the window; cursor parks once past the last page
  function automatic void blit_beat(draw_item_t it);
    int sx;
    int sy;
    int npages;
    int tail;
    int nrows;
    if (it.first) begin
      blit_col = 0;
      blit_pg = 0;
    end
    if (it.xe < it.xs || it.ye < it.ys) return;
    sx = int'(it.xe) - int'(it.xs) + 1;
    sy = int'(it.ye) - int'(it.ys) + 1;
    npages = (sy + PageRows - 1) / PageRows;
    tail = sy % PageRows;
    if (tail == 0) tail = PageRows;
    if (blit_pg >= npages) return;
    nrows = (blit_pg == npages - 1) ? tail : PageRows;
    for (int m = 0; m < nrows; m++)
      plot(it.xs + blit_col, it.ys + blit_pg * PageRows + m, {1'b0, it.bits[m]});
    blit_col++;
    if (blit_col >= sx) begin
      blit_col = 0;
      blit_pg = (blit_pg + 1) & 63;
    end
    blit_col &= 255;
  endfunction

  function automatic logic [7:0] draw_step(draw_item_t it);
    case (it.op)
      OpPixel: plot(it.xs, it.ys, it.mode);
      OpRect:  fill_window(it);
      OpBlit:  blit_beat(it);
      default: begin
        if (it.xs < Width && it.ys < rows_visible())
          return shadow_store[(it.ys / PageRows) * Width + it.xs];
      end
    endcase
    return 8'h00;
  endfunction

  // Input driver: holds a beat until taken, idles at random otherwise
  always @(negedge clk_i) begin
    draw_item_t cur;
    if (rst_ni) begin
      if (!in_valid_i || beats_taken == beats_sent) begin
        if (draw_q.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          cur = draw_q.pop_front();
          op_i          <= cur.op;
          x_start_i     <= cur.xs;
          y_start_i     <= cur.ys;
          x_end_i       <= cur.xe;
          y_end_i       <= cur.ye;
          pixel_mode_i  <= cur.mode;
          bitmap_byte_i <= cur.bits;
          first_byte_i  <= cur.first;
          in_valid_i    <= 1'b1;
          beats_sent    <= beats_sent + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < IdlePct);
  end

  // Monitor: predict on input beats, check output beats in order
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        read_data_want_q.push_back(draw_step({op_i, x_start_i, y_start_i, x_end_i,
                                              y_end_i, pixel_mode_i, bitmap_byte_i,
                                              first_byte_i}));
        beats_taken <= beats_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (read_data_want_q.size() == 0) begin
          $error("read_data beat with none expected: actual %02h", read_data_o);
          failed = 1'b1;
        end else begin
          want = read_data_want_q.pop_front();
          if (read_data_o !== want) begin
            $error("read_data mismatch: expected %02h, actual %02h", want, read_data_o);
            failed = 1'b1;
          end
        end
      end
    end
  end

  function automatic draw_item_t rand_item();
    draw_item_t it;
    it.op    = 2'($urandom);
    it.xs    = 8'($urandom);
    it.ys    = 8'($urandom);
    it.xe    = 8'($urandom);
    it.ye    = 8'($urandom);
    it.mode  = 2'($urandom);
    it.bits  = 8'($urandom);
    it.first = 1'($urandom);
    return it;
  endfunction

  // Coordinates bunched near the origin so reads see earlier writes
  function automatic logic [7:0] near_x();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 8'($urandom_range(0, 31));
    if (k < 9) return 8'($urandom_range(0, Width - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] near_y();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 8'($urandom_range(0, 23));
    if (k < 9) return 8'($urandom_range(0, 63));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_item(input logic [1:0] op, input logic [7:0] xs, input logic [7:0] ys,
                          input logic [7:0] xe, input logic [7:0] ye, input logic [1:0] mode,
                          input logic [7:0] bits, input logic first);
    draw_q.push_back({op, xs, ys, xe, ye, mode, bits, first});
  endtask

  // Random traffic; bytes past a blit window and stray blit beats not counted
  task automatic random_phase(input int budget);
    draw_item_t it;
    int         done_n;
    int         pick;
    int         k;
    int         w;
    int         h;
    int         total;
    int         n;
    done_n = 0;
    while (done_n < budget) begin
      pick = $urandom_range(0, 99);
      it = rand_item();
      if (pick < 28) begin
        it.op = OpPixel;
        it.xs = near_x();
        it.ys = near_y();
        draw_q.push_back(it);
        done_n++;
      end else if (pick < 50) begin
        it.op = OpRead;
        it.xs = near_x();
        it.ys = near_y();
        draw_q.push_back(it);
        done_n++;
      end else if (pick < 62) begin
        it.op = OpRect;
        k = $urandom_range(0, 99);
        if (k < 5) begin
          it.xs = 8'($urandom_range(0, 40));
          it.xe = 8'($urandom_range(100, 255));
          it.ys = 8'($urandom_range(0, 20));
          it.ye = 8'($urandom_range(40, 255));
        end else if (k < 12) begin
          it.xs = 8'($urandom_range(1, 255));
          it.xe = 8'($urandom_range(0, it.xs - 1));
        end else begin
          it.xs = near_x();
          it.ys = near_y();
          it.xe = it.xs + 8'($urandom_range(0, 9));
          it.ye = it.ys + 8'($urandom_range(0, 15));
        end
        draw_q.push_back(it);
        done_n++;
      end else if (pick < 94) begin
        // well-formed blit sequence, sometimes cut short or overrun
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 20);
        it.op = OpBlit;
        it.xs = near_x();
        it.ys = near_y();
        it.xe = it.xs + 8'(w - 1);
        it.ye = it.ys + 8'(h - 1);
        if ($urandom_range(0, 19) == 0 && it.ys != 0) it.ye = it.ys - 8'd1;
        total = w * ((h + PageRows - 1) / PageRows);
        k = $urandom_range(0, 99);
        if (k < 15) n = $urandom_range(1, total);
        else if (k < 30) n = total + $urandom_range(1, 3);
        else n = total;
        for (int i = 0; i < n; i++) begin
          it.bits = 8'($urandom);
          it.mode = 2'($urandom);
          if (i == 0) it.first = ($urandom_range(0, 9) != 0);
          else it.first = ($urandom_range(0, 49) == 0);
          draw_q.push_back(it);
        end
        done_n += (n < total) ? n : total;
      end else begin
        it.op = OpBlit;
        draw_q.push_back(it);
      end
    end
  endtask

  task automatic wait_idle();
    while (draw_q.size() != 0 || beats_taken != beats_sent || read_data_want_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_rows(input logic [6:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    rows_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sequence of phases
  initial begin
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, clipping, both toggle codes, empty windows, blit tail
    add_item(OpPixel, 8'd0,   8'd0,   8'd9,   8'd200, ModeSet,       8'h5A, 1'b1);
    add_item(OpPixel, 8'd127, 8'd63,  8'd0,   8'd0,   ModeSet,       8'h00, 1'b0);
    add_item(OpPixel, 8'd5,   8'd9,   8'd255, 8'd255, ModeToggle,    8'hFF, 1'b0);
    add_item(OpPixel, 8'd127, 8'd63,  8'd0,   8'd0,   ModeToggleAlt, 8'h00, 1'b0);
    add_item(OpPixel, 8'd255, 8'd255, 8'd0,   8'd0,   ModeSet,       8'h00, 1'b0);
    add_item(OpPixel, 8'd128, 8'd0,   8'd0,   8'd0,   ModeSet,       8'h00, 1'b0);
    add_item(OpRead,  8'd127, 8'd63,  8'd0,   8'd0,   ModeClear,     8'h00, 1'b0);
    add_item(OpRead,  8'd5,   8'd9,   8'd0,   8'd0,   ModeClear,     8'h00, 1'b0);
    add_item(OpRead,  8'd0,   8'd0,   8'd0,   8'd0,   ModeClear,     8'h00, 1'b0);
    add_item(OpRead,  8'd255, 8'd255, 8'd0,   8'd0,   ModeSet,       8'hFF, 1'b1);
    add_item(OpRect,  8'd10,  8'd3,   8'd20,  8'd17,  ModeToggle,    8'h00, 1'b0);
    add_item(OpRect,  8'd12,  8'd5,   8'd14,  8'd6,   ModeClear,     8'h00, 1'b0);
    add_item(OpRect,  8'd30,  8'd0,   8'd20,  8'd10,  ModeSet,       8'h00, 1'b0);
    add_item(OpRect,  8'd0,   8'd0,   8'd255, 8'd255, ModeToggleAlt, 8'h00, 1'b0);
    add_item(OpRead,  8'd127, 8'd63,  8'd0,   8'd0,   ModeClear,     8'h00, 1'b0);
    add_item(OpRect,  8'd0,   8'd0,   8'd255, 8'd255, ModeClear,     8'h00, 1'b0);
    add_item(OpBlit,  8'd40,  8'd2,   8'd42,  8'd12,  ModeClear,     8'hFF, 1'b1);
    add_item(OpBlit,  8'd40,  8'd2,   8'd42,  8'd12,  ModeClear,     8'hA5, 1'b0);
    add_item(OpBlit,  8'd40,  8'd2,   8'd42,  8'd12,  ModeClear,     8'h3C, 1'b0);
    add_item(OpBlit,  8'd40,  8'd2,   8'd42,  8'd12,  ModeClear,     8'h81, 1'b0);
    add_item(OpBlit,  8'd40,  8'd2,   8'd42,  8'd12,  ModeClear,     8'h7E, 1'b0);
    add_item(OpBlit,  8'd40,  8'd2,   8'd42,  8'd12,  ModeClear,     8'h0F, 1'b0);
    add_item(OpBlit,  8'd40,  8'd2,   8'd42,  8'd12,  ModeClear,     8'hFF, 1'b0);
    add_item(OpBlit,  8'd50,  8'd10,  8'd49,  8'd20,  ModeClear,     8'hFF, 1'b1);
    add_item(OpRead,  8'd41,  8'd8,   8'd0,   8'd0,   ModeClear,     8'h00, 1'b0);
    add_item(OpRead,  8'd40,  8'd12,  8'd0,   8'd0,   ModeClear,     8'h00, 1'b0);
    random_phase(80);
    wait_idle();

    // row count above the store height is limited
    write_rows(7'd127);
    random_phase(100);
    wait_idle();

    // one page of rows, and a stretch without idling on either side
    write_rows(7'd8);
    steady = 1'b1;
    random_phase(100);
    wait_idle();
    steady = 1'b0;

    write_rows(RowsAtReset);
    random_phase(100);
    wait_idle();

    write_rows(7'($urandom_range(8, 64)));
    random_phase(100);
    wait_idle();

    write_rows(7'($urandom_range(9, 63)));
    random_phase(100);
    wait_idle();

    if (failed) begin
      $display("testbench failed");
    end else begin
      $display("testbench passed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
